FILE: rtl/core/thbp_pkg.sv
// thbp_pkg: shared types and constants of the tap/hold band phase controller
// beat payloads, register map, mode and phase codes
// no dependencies
package thbp_pkg;

	localparam int unsigned AddrWidth = 5;
	localparam int unsigned IdxWidth  = 3;
	localparam int unsigned TimeWidth = 32;

	typedef logic [TimeWidth-1:0] time_ms_t;
	typedef logic [15:0]          dur_ms_t;

	typedef enum logic [IdxWidth-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_HOLD         = 3'd1,
		REG_FIRST_PHASE  = 3'd2,
		REG_SECOND_PHASE = 3'd3,
		REG_DUAL_HOLD    = 3'd4,
		REG_SINGLE_HOLD  = 3'd5,
		REG_INIT_MODE    = 3'd6
	} reg_idx_t;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_FIRST  = 2'd0;
	localparam mode_t MODE_SECOND = 2'd1;
	localparam mode_t MODE_BOTH   = 2'd2;

	typedef logic [1:0] switch_t;
	localparam switch_t SW_NONE   = 2'd0;
	localparam switch_t SW_FIRST  = 2'd1;
	localparam switch_t SW_SECOND = 2'd2;

	localparam logic PHASE_FIRST  = 1'b0;
	localparam logic PHASE_SECOND = 1'b1;

	localparam dur_ms_t RST_DEBOUNCE     = 16'd50;
	localparam dur_ms_t RST_HOLD         = 16'd1000;
	localparam dur_ms_t RST_FIRST_PHASE  = 16'd3000;
	localparam dur_ms_t RST_SECOND_PHASE = 16'd3000;
	localparam dur_ms_t RST_DUAL_HOLD    = 16'd10000;
	localparam dur_ms_t RST_SINGLE_HOLD  = 16'd3000;
	localparam mode_t   RST_INIT_MODE    = MODE_BOTH;

	typedef struct packed {
		dur_ms_t debounce_ms;
		dur_ms_t hold_ms;
		dur_ms_t first_phase_ms;
		dur_ms_t second_phase_ms;
		dur_ms_t dual_hold_ms;
		dur_ms_t single_hold_ms;
		mode_t   initial_band_mode;
		logic    mode_load;
	} cfg_t;

	typedef struct packed {
		time_ms_t now_ms;
		logic     button_pressed;
	} poll_t;

	typedef struct packed {
		logic    mute_pulse;
		mode_t   band_mode;
		logic    radio_phase;
		switch_t phase_switch;
		logic    save_request;
		dur_ms_t alert_hold_ms;
	} result_t;

	// code three reads as both
	function automatic mode_t clip_mode(input mode_t m);
		return (m == 2'd3) ? MODE_BOTH : m;
	endfunction

	function automatic mode_t next_mode(input mode_t m);
		mode_t n;
		case (m)
			MODE_BOTH:  n = MODE_FIRST;
			MODE_FIRST: n = MODE_SECOND;
			default:    n = MODE_BOTH;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/core/thbp_poll_if.sv
// thbp_poll_if: valid/ready channel carrying one poll beat
// depends on thbp_pkg
interface thbp_poll_if;
	logic            valid;
	logic            ready;
	thbp_pkg::poll_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/thbp_result_if.sv
// thbp_result_if: valid/ready channel carrying one result beat
// depends on thbp_pkg
interface thbp_result_if;
	logic              valid;
	logic              ready;
	thbp_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/thbp_cfg_regs.sv
// thbp_cfg_regs: apb register file of the controller
// raises mode_load the cycle after an initial band mode write
// depends on thbp_pkg
module thbp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [thbp_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output thbp_pkg::cfg_t                 cfg
);

	thbp_pkg::dur_ms_t debounce_q, hold_q, first_q, second_q, dual_q, single_q;
	thbp_pkg::mode_t   init_mode_q;
	logic              mode_load_q;
	logic              wr_en;
	logic [thbp_pkg::IdxWidth-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[thbp_pkg::AddrWidth-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= thbp_pkg::RST_DEBOUNCE;
			hold_q      <= thbp_pkg::RST_HOLD;
			first_q     <= thbp_pkg::RST_FIRST_PHASE;
			second_q    <= thbp_pkg::RST_SECOND_PHASE;
			dual_q      <= thbp_pkg::RST_DUAL_HOLD;
			single_q    <= thbp_pkg::RST_SINGLE_HOLD;
			init_mode_q <= thbp_pkg::RST_INIT_MODE;
			mode_load_q <= 1'b0;
		end else begin
			mode_load_q <= 1'b0;
			if (wr_en) begin
				case (idx)
					thbp_pkg::REG_DEBOUNCE:     debounce_q <= pwdata[15:0];
					thbp_pkg::REG_HOLD:         hold_q     <= pwdata[15:0];
					thbp_pkg::REG_FIRST_PHASE:  first_q    <= pwdata[15:0];
					thbp_pkg::REG_SECOND_PHASE: second_q   <= pwdata[15:0];
					thbp_pkg::REG_DUAL_HOLD:    dual_q     <= pwdata[15:0];
					thbp_pkg::REG_SINGLE_HOLD:  single_q   <= pwdata[15:0];
					thbp_pkg::REG_INIT_MODE: begin
						init_mode_q <= pwdata[1:0];
						mode_load_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			thbp_pkg::REG_DEBOUNCE:     prdata = {16'd0, debounce_q};
			thbp_pkg::REG_HOLD:         prdata = {16'd0, hold_q};
			thbp_pkg::REG_FIRST_PHASE:  prdata = {16'd0, first_q};
			thbp_pkg::REG_SECOND_PHASE: prdata = {16'd0, second_q};
			thbp_pkg::REG_DUAL_HOLD:    prdata = {16'd0, dual_q};
			thbp_pkg::REG_SINGLE_HOLD:  prdata = {16'd0, single_q};
			thbp_pkg::REG_INIT_MODE:    prdata = {30'd0, init_mode_q};
			default:                    prdata = 32'd0;
		endcase
	end

	assign cfg = '{
		debounce_ms:       debounce_q,
		hold_ms:           hold_q,
		first_phase_ms:    first_q,
		second_phase_ms:   second_q,
		dual_hold_ms:      dual_q,
		single_hold_ms:    single_q,
		initial_band_mode: init_mode_q,
		mode_load:         mode_load_q
	};

endmodule

FILE: rtl/core/thbp_poll_engine.sv
// thbp_poll_engine: button, band mode and phase state with the per-poll update
// result is combinational from the registered poll and the state
// depends on thbp_pkg
module thbp_poll_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  thbp_pkg::cfg_t    cfg,
	input  logic              step,
	input  thbp_pkg::poll_t   poll,
	output thbp_pkg::result_t res
);

	logic               raw_q, stable_q, fired_q, phase_q;
	thbp_pkg::time_ms_t last_chg_q, press_q, phase_start_q;
	thbp_pkg::mode_t    mode_q;

	thbp_pkg::time_ms_t now, last_chg_n, press_n, pst_h, pst_n;
	logic               btn, deb_ok, stab_chg, stable_n, fired_a, fired_n;
	logic               mute, hold, phase_h, phase_n, save;
	thbp_pkg::mode_t    mode_n, load_mode;
	thbp_pkg::switch_t  sw_h, sw_n;

	assign now = poll.now_ms;
	assign btn = poll.button_pressed;

	always_comb begin
		// debounce
		last_chg_n = (btn != raw_q) ? now : last_chg_q;
		deb_ok     = (now - last_chg_n) >= {16'd0, cfg.debounce_ms};
		stab_chg   = deb_ok && (btn != stable_q);
		stable_n   = stab_chg ? btn : stable_q;
		press_n    = (stab_chg && btn) ? now : press_q;
		fired_a    = (stab_chg && btn) ? 1'b0 : fired_q;
		mute       = stab_chg && !btn && !fired_q;

		// long hold
		hold    = stable_n && !fired_a && ((now - press_n) >= {16'd0, cfg.hold_ms});
		fired_n = fired_a | hold;
		save    = hold;
		mode_n  = hold ? thbp_pkg::next_mode(mode_q) : mode_q;
		phase_h = phase_q;
		pst_h   = phase_start_q;
		sw_h    = thbp_pkg::SW_NONE;
		if (hold && mode_n == thbp_pkg::MODE_SECOND && phase_q == thbp_pkg::PHASE_FIRST) begin
			phase_h = thbp_pkg::PHASE_SECOND;
			pst_h   = now;
			sw_h    = thbp_pkg::SW_SECOND;
		end else if (hold && mode_n == thbp_pkg::MODE_FIRST
				&& phase_q == thbp_pkg::PHASE_SECOND) begin
			phase_h = thbp_pkg::PHASE_FIRST;
			pst_h   = now;
			sw_h    = thbp_pkg::SW_FIRST;
		end

		// time slice
		phase_n = phase_h;
		pst_n   = pst_h;
		sw_n    = sw_h;
		if (phase_h == thbp_pkg::PHASE_FIRST) begin
			if (mode_n != thbp_pkg::MODE_FIRST
					&& (now - pst_h) >= {16'd0, cfg.first_phase_ms}) begin
				phase_n = thbp_pkg::PHASE_SECOND;
				pst_n   = now;
				sw_n    = thbp_pkg::SW_SECOND;
			end
		end else begin
			if (mode_n != thbp_pkg::MODE_SECOND
					&& (now - pst_h) >= {16'd0, cfg.second_phase_ms}) begin
				phase_n = thbp_pkg::PHASE_FIRST;
				pst_n   = now;
				sw_n    = thbp_pkg::SW_FIRST;
			end
		end
	end

	assign load_mode = thbp_pkg::clip_mode(cfg.initial_band_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q         <= 1'b0;
			stable_q      <= 1'b0;
			last_chg_q    <= '0;
			press_q       <= '0;
			fired_q       <= 1'b0;
			mode_q        <= thbp_pkg::RST_INIT_MODE;
			phase_q       <= thbp_pkg::PHASE_FIRST;
			phase_start_q <= '0;
		end else if (cfg.mode_load) begin
			mode_q        <= load_mode;
			phase_q       <= (load_mode == thbp_pkg::MODE_SECOND);
			phase_start_q <= '0;
		end else if (step) begin
			raw_q         <= btn;
			stable_q      <= stable_n;
			last_chg_q    <= last_chg_n;
			press_q       <= press_n;
			fired_q       <= fired_n;
			mode_q        <= mode_n;
			phase_q       <= phase_n;
			phase_start_q <= pst_n;
		end
	end

	assign res = '{
		mute_pulse:    mute,
		band_mode:     mode_n,
		radio_phase:   phase_n,
		phase_switch:  sw_n,
		save_request:  save,
		alert_hold_ms: (mode_n == thbp_pkg::MODE_BOTH) ? cfg.dual_hold_ms
		                                               : cfg.single_hold_ms
	};

endmodule

FILE: rtl/core/tap_hold_button_band_phase_controller_core.sv
// tap_hold_button_band_phase_controller_core: top level of the controller
// input register, poll engine, result register and apb registers
// depends on thbp_pkg, thbp_poll_if, thbp_result_if, thbp_cfg_regs, thbp_poll_engine

// One poll beat is taken per clock unless the result side stalls, and gives
// exactly one result beat: the poll is captured in an input register, the
// debounce, hold and phase update is combinational on the state registers,
// and the result lands in an output register. The state is updated as the
// poll moves into the output register, so the next poll sees it without a
// bubble, and a stalled result only holds the pipe once both registers are
// full. Writing the initial band mode register reloads band mode and radio
// phase via mode_load; configuration is expected while no polls are in flight.
module tap_hold_button_band_phase_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	thbp_poll_if.sink                      poll,
	thbp_result_if.source                  result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [thbp_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	thbp_pkg::cfg_t    cfg;
	thbp_pkg::poll_t   poll_s1;
	thbp_pkg::result_t res, res_s2;
	logic              valid_s1, valid_s2, advance;

	thbp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (poll.ready) begin
				valid_s1 <= poll.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			poll_s1 <= poll.data;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	thbp_poll_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.poll   (poll_s1),
		.res    (res)
	);

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.band_mode != 2'd3)
		else $error("band mode left its legal range");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.band_mode == thbp_pkg::MODE_FIRST
		|-> result.data.radio_phase == thbp_pkg::PHASE_FIRST)
		else $error("first only mode with second radio phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.band_mode == thbp_pkg::MODE_SECOND
		|-> result.data.radio_phase == thbp_pkg::PHASE_SECOND)
		else $error("second only mode with first radio phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.data.mute_pulse && result.data.save_request))
		else $error("mute and save in one beat");
`endif

endmodule
